FILE: design/sae_pkg.sv
// ----------------------------------------------------------------------------
// sae_pkg
// Shared types and constants of the sensor advertisement encoder.
// ----------------------------------------------------------------------------
package sae_pkg;

	localparam int PAYLOAD_BYTES = 24;
	localparam int PAYLOAD_BITS  = PAYLOAD_BYTES * 8;
	localparam int POS_W         = $clog2(PAYLOAD_BYTES);
	localparam int IN_DATA_W     = 208;

	localparam logic [POS_W-1:0] LAST_POS = POS_W'(PAYLOAD_BYTES - 1);

	// Byte 0 of the payload sits in the top byte, so the serializer shifts left.
	typedef logic [PAYLOAD_BITS-1:0] payload_t;

	localparam logic [7:0] FORMAT_CODE = 8'd5;

endpackage

FILE: design/sensor_advertisement_encoder.sv
// A record passes stages s1 and s2, the payload queue and the shift register
// before its first byte appears. The byte serializer sets throughput; records
// are taken meanwhile until the two-entry payload queue and pipeline fill.
// Reset is asynchronous and active low; it empties the pipeline and queue
// and sets battery_sentinel to 65535. No clearing pass follows reset.
// ----------------------------------------------------------------------------
// sensor_advertisement_encoder
// Converts raw sensor records into 24-byte advertisement payload streams.
// ----------------------------------------------------------------------------
module sensor_advertisement_encoder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [15:0]                   cfg_wr_data,   // battery_sentinel
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// temp_millicelsius, humid_millipercent, press_pascal, accel_x, accel_y,
	// accel_z, battery_millivolts, tx_dbm, movement_count, sequence_number,
	// mac_address, zero fill
	input  logic [sae_pkg::IN_DATA_W-1:0] s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [7:0]                    m_tdata,       // payload_byte
	output logic                          m_tlast        // last_byte
);

	logic [15:0]       battery_sentinel_q;
	logic              push_valid, push_ready;
	logic              pop_valid, pop_ready;
	sae_pkg::payload_t push_data, pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			battery_sentinel_q <= 16'hFFFF;
		end else if (cfg_wr_en) begin
			battery_sentinel_q <= cfg_wr_data;
		end
	end

	sae_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.battery_sentinel (battery_sentinel_q),
		.s_tvalid         (s_tvalid),
		.s_tready         (s_tready),
		.s_tdata          (s_tdata),
		.push_valid       (push_valid),
		.push_ready       (push_ready),
		.push_data        (push_data)
	);

	sae_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	sae_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

FILE: design/sae_front.sv
// ----------------------------------------------------------------------------
// sae_front
// Two-stage conversion pipeline: unpacks a sensor record, scales and clamps
// each reading and assembles the 24-byte payload for the queue.
// ----------------------------------------------------------------------------
module sae_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [15:0]                  battery_sentinel,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [sae_pkg::IN_DATA_W-1:0] s_tdata,
	output logic                         push_valid,
	input  logic                         push_ready,
	output sae_pkg::payload_t            push_data
);

	// Rounded-up 2^23/5; exact truncating division for operands below 2^22.
	localparam logic [20:0] RECIP5     = 21'd1677722;
	localparam int          RECIP_SH   = 23;
	localparam logic [17:0] TEMP_MAX   = 18'd32767;
	localparam logic [15:0] HUMID_MAX  = 16'd40000;
	localparam logic [17:0] PRESS_OFS  = 18'd50000;
	localparam logic [17:0] PRESS_MAX  = 18'd65534;
	localparam logic [15:0] BATT_OFS   = 16'd1600;
	localparam logic [15:0] BATT_MAX   = 16'd2046;
	localparam logic [10:0] BATT_NONE  = 11'd2047;
	localparam logic signed [8:0] TX_OFS = 9'sd40;
	localparam logic [7:0]  TX_MAX     = 8'd30;

	logic signed [20:0] temp_in;
	logic signed [17:0] humid_in;
	logic [17:0]        press_in;
	logic [47:0]        accel_in;
	logic [15:0]        batt_in;
	logic signed [7:0]  tx_in;
	logic [7:0]         move_in;
	logic [15:0]        seq_in;
	logic [47:0]        mac_in;

	assign temp_in  = s_tdata[20:0];
	assign humid_in = s_tdata[38:21];
	assign press_in = s_tdata[56:39];
	assign accel_in = s_tdata[104:57];
	assign batt_in  = s_tdata[120:105];
	assign tx_in    = s_tdata[128:121];
	assign move_in  = s_tdata[136:129];
	assign seq_in   = s_tdata[152:137];
	assign mac_in   = s_tdata[200:153];

	// Stage 1 conversions that need no multiplier.
	logic signed [21:0] temp_ext;
	logic [21:0]        temp_abs;
	logic [17:0]        humid_dbl;
	logic [17:0]        press_sub;
	logic [15:0]        press_enc;
	logic [15:0]        batt_sub;
	logic [10:0]        batt_code;
	logic signed [8:0]  tx_sum;
	logic [7:0]         tx_half;
	logic [4:0]         tx_code;

	always_comb begin
		temp_ext  = 22'(temp_in);
		temp_abs  = temp_ext[21] ? 22'(-temp_ext) : 22'(temp_ext);
		// Negative humidity always ends at zero after the clamp.
		humid_dbl = humid_in[17] ? 18'd0 : {humid_in[16:0], 1'b0};

		press_sub = press_in - PRESS_OFS;
		if (press_in < PRESS_OFS) begin
			press_enc = 16'd0;
		end else if (press_sub > PRESS_MAX) begin
			press_enc = PRESS_MAX[15:0];
		end else begin
			press_enc = press_sub[15:0];
		end

		batt_sub = batt_in - BATT_OFS;
		if (batt_in == battery_sentinel) begin
			batt_code = BATT_NONE;
		end else if (batt_in < BATT_OFS) begin
			batt_code = 11'd0;
		end else if (batt_sub > BATT_MAX) begin
			batt_code = BATT_MAX[10:0];
		end else begin
			batt_code = batt_sub[10:0];
		end

		tx_sum  = 9'(tx_in) + TX_OFS;
		tx_half = tx_sum[8:1];
		if (tx_sum[8]) begin
			tx_code = 5'd0;
		end else if (tx_half > TX_MAX) begin
			tx_code = TX_MAX[4:0];
		end else begin
			tx_code = tx_half[4:0];
		end
	end

	logic        valid_s1, valid_s2;
	logic        temp_neg_s1, temp_neg_s2;
	logic [21:0] temp_abs_s1;
	logic [17:0] humid_dbl_s1;
	logic [15:0] press_s1, power_s1;
	logic [47:0] accel_s1, mac_s1;
	logic [7:0]  move_s1;
	logic [15:0] seq_s1;
	logic [17:0] temp_quo_s2;
	logic [15:0] humid_quo_s2;
	logic [15:0] press_s2, power_s2;
	logic [47:0] accel_s2, mac_s2;
	logic [7:0]  move_s2;
	logic [15:0] seq_s2;

	logic adv_s2;
	assign adv_s2   = !valid_s2 || push_ready;
	assign s_tready = !valid_s1 || adv_s2;

	logic [42:0] temp_prod;
	logic [38:0] humid_prod;
	assign temp_prod  = 43'(temp_abs_s1) * 43'(RECIP5);
	assign humid_prod = 39'(humid_dbl_s1) * 39'(RECIP5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready) begin
			temp_neg_s1  <= temp_ext[21];
			temp_abs_s1  <= temp_abs;
			humid_dbl_s1 <= humid_dbl;
			press_s1     <= press_enc;
			power_s1     <= {batt_code, tx_code};
			accel_s1     <= accel_in;
			move_s1      <= move_in;
			seq_s1       <= seq_in;
			mac_s1       <= mac_in;
		end
		if (adv_s2) begin
			temp_neg_s2  <= temp_neg_s1;
			temp_quo_s2  <= temp_prod[RECIP_SH+17:RECIP_SH];
			humid_quo_s2 <= humid_prod[RECIP_SH+15:RECIP_SH];
			press_s2     <= press_s1;
			power_s2     <= power_s1;
			accel_s2     <= accel_s1;
			move_s2      <= move_s1;
			seq_s2       <= seq_s1;
			mac_s2       <= mac_s1;
		end
	end

	// Clamping after the divide, then payload assembly.
	logic [15:0] temp_mag;
	logic [15:0] temp_enc;
	logic [15:0] humid_enc;

	always_comb begin
		temp_mag  = (temp_quo_s2 > TEMP_MAX) ? TEMP_MAX[15:0] : temp_quo_s2[15:0];
		temp_enc  = temp_neg_s2 ? 16'(-temp_mag) : temp_mag;
		humid_enc = (humid_quo_s2 > HUMID_MAX) ? HUMID_MAX : humid_quo_s2;
	end

	// accel_s2 holds z in the top word and x in the bottom word.
	assign push_valid = valid_s2;
	assign push_data  = {sae_pkg::FORMAT_CODE, temp_enc, humid_enc, press_s2,
		accel_s2[15:0], accel_s2[31:16], accel_s2[47:32], power_s2, move_s2,
		seq_s2, mac_s2};

endmodule

FILE: design/sae_queue.sv
// ----------------------------------------------------------------------------
// sae_queue
// Two-entry payload queue between the conversion pipeline and the serializer.
// ----------------------------------------------------------------------------
module sae_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  sae_pkg::payload_t push_data,
	output logic              pop_valid,
	input  logic              pop_ready,
	output sae_pkg::payload_t pop_data
);

	sae_pkg::payload_t entry_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push, do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

FILE: design/sae_back.sv
// ----------------------------------------------------------------------------
// sae_back
// Serializer: sends a payload a byte per cycle unless stalled, byte 0 first.
// ----------------------------------------------------------------------------
module sae_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pop_valid,
	output logic              pop_ready,
	input  sae_pkg::payload_t pop_data,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,
	output logic              m_tlast
);

	sae_pkg::payload_t           shift_q;
	logic [sae_pkg::POS_W-1:0]   pos_q;
	logic                        busy_q;
	logic                        at_last;

	assign at_last   = (pos_q == sae_pkg::LAST_POS);
	assign pop_ready = !busy_q || (m_tready && at_last);
	assign m_tvalid  = busy_q;
	assign m_tdata   = shift_q[sae_pkg::PAYLOAD_BITS-1 -: 8];
	assign m_tlast   = at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= '0;
		end else if (pop_valid && pop_ready) begin
			busy_q <= 1'b1;
			pos_q  <= '0;
		end else if (busy_q && m_tready) begin
			if (at_last) begin
				busy_q <= 1'b0;
			end else begin
				pos_q <= pos_q + sae_pkg::POS_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			shift_q <= pop_data;
		end else if (busy_q && m_tready) begin
			shift_q <= {shift_q[sae_pkg::PAYLOAD_BITS-9:0], 8'd0};
		end
	end

endmodule
